[design/dzv_pkg.sv]
package dzv_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned MAX_BYTES  = 10;
    localparam int unsigned CNT_W      = $clog2(MAX_BYTES + 1);
    localparam int unsigned SIGN_BIT   = 63;
    localparam logic [7:0]  MORE_FLAG  = 8'h80;
    localparam logic [7:0]  GROUP_MASK = 8'h7f;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // one classified value waiting for serialization
    typedef struct packed {
        logic [VALUE_W-1:0] payload;
        logic [CNT_W-1:0]   nbytes;
    } t_entry;

    // handshake between the queue and one of its neighbors
    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

    // number of varint bytes for a payload: one plus index of the top nonzero group
    function automatic logic [CNT_W-1:0] byte_count(input logic [VALUE_W-1:0] p);
        logic [CNT_W-1:0] n;
        n = CNT_W'(1);
        for (int k = 1; k < MAX_BYTES; k++) begin
            if ((p >> (GROUP_BITS * k)) != '0) begin
                n = CNT_W'(k + 1);
            end
        end
        return n;
    endfunction

endpackage

[design/dzv_front.sv]
module dzv_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [63:0]     i_value,
    input  logic            i_restart,
    output dzv_pkg::t_entry o_entry,
    output logic            o_push,
    input  logic            i_q_ready
);
    import dzv_pkg::*;

    logic               r_delta_mode;
    logic [VALUE_W-1:0] r_prev;
    logic [VALUE_W-1:0] r_payload;
    logic               r_valid;
    logic [VALUE_W-1:0] n_payload;
    logic [VALUE_W-1:0] prev_eff;
    logic [VALUE_W-1:0] diff;
    logic               accept;

    // stage holds one item; it frees when the queue takes it
    assign o_push  = r_valid && i_q_ready;
    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;

    // delta and zigzag map in delta mode; the raw value passes through in plain mode
    always_comb begin
        prev_eff = i_restart ? '0 : r_prev;
        diff     = i_value - prev_eff;
        if (r_delta_mode) begin
            n_payload = (diff << 1) ^ {VALUE_W{diff[SIGN_BIT]}};
        end else begin
            n_payload = i_value;
        end
    end

    // classify: byte count from the registered payload
    assign o_entry.payload = r_payload;
    assign o_entry.nbytes  = byte_count(r_payload);

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_delta_mode <= i_cfg_wdata;
        end
    end

    // previous value and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_prev <= i_value;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= n_payload;
        end
    end

endmodule

[design/dzv_queue.sv]
module dzv_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dzv_pkg::t_entry i_entry,
    output dzv_pkg::t_hs    o_wr_hs,
    input  logic            i_push,
    output dzv_pkg::t_entry o_entry,
    output dzv_pkg::t_hs    o_rd_hs,
    input  logic            i_pop
);
    import dzv_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_wr_hs.ready = (r_count != QCNT_W'(QDEPTH));
    assign o_wr_hs.valid = i_push;
    assign o_rd_hs.valid = (r_count != '0);
    assign o_rd_hs.ready = i_pop;
    assign o_entry       = r_mem[r_rptr];

    assign do_push = i_push && o_wr_hs.ready;
    assign do_pop  = i_pop && o_rd_hs.valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

[design/dzv_back.sv]
module dzv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dzv_pkg::t_entry i_entry,
    input  logic            i_q_valid,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last_byte
);
    import dzv_pkg::*;

    logic               r_busy;
    logic [VALUE_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_left;
    logic               r_ovalid;
    logic [7:0]         r_obyte;
    logic               r_olast;
    logic               out_free;
    logic               emit;
    logic               is_last;

    assign out_free = !r_ovalid || i_ready;
    assign emit     = r_busy && out_free;
    assign is_last  = (r_left == CNT_W'(1));
    // next value loads as the current one sends its last beat
    assign o_pop    = i_q_valid && (!r_busy || (emit && is_last));

    assign o_valid     = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_last_byte = r_olast;

    // serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_left <= i_entry.nbytes;
            end else if (emit) begin
                r_busy <= !is_last;
                r_left <= r_left - 1'b1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // shift register and output beat
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_entry.payload;
        end else if (emit) begin
            r_shift <= r_shift >> GROUP_BITS;
        end
        if (emit) begin
            r_obyte <= (r_shift[7:0] & GROUP_MASK) | (is_last ? 8'h00 : MORE_FLAG);
            r_olast <= is_last;
        end
    end

endmodule

[design/delta_zigzag_varint_encoder_core.sv]
// Path: payload register, queue, serializer shift register, output register.
// Throughput: one output beat per cycle while the receiver is ready; a value of
//   N bytes (1..10) takes N serializer beats, so long values slow the intake.
// A 2-entry queue separates the classify stage from the byte serializer.
// Reset (synchronous, active low): previous value 0, delta mode on, queue empty.
module delta_zigzag_varint_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_value,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);
    import dzv_pkg::*;

    t_entry front_entry;
    t_entry head_entry;
    t_hs    wr_hs;
    t_hs    rd_hs;
    logic   push;
    logic   pop;

    dzv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_restart   (i_restart),
        .o_entry     (front_entry),
        .o_push      (push),
        .i_q_ready   (wr_hs.ready)
    );

    dzv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_entry (front_entry),
        .o_wr_hs (wr_hs),
        .i_push  (push),
        .o_entry (head_entry),
        .o_rd_hs (rd_hs),
        .i_pop   (pop)
    );

    dzv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (head_entry),
        .i_q_valid   (rd_hs.valid),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dzv_pkg::*;

    localparam int DIR_ROWS    = 19;
    localparam int RAND_PHASES = 5;
    localparam int PHASE_ITEMS = 86;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 16;
    localparam int STALL_LIMIT = 3000;

    // one item of stimulus; enc/cnt hold typed-in bytes when known is set
    typedef struct packed {
        logic        mode;
        logic [63:0] value;
        logic        restart;
        logic        known;
        logic [3:0]  cnt;
        logic [79:0] enc;
    } t_dir_row;

    // one expected output beat
    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid     = 1'b0;
    logic [63:0] i_value     = '0;
    logic        i_restart   = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    // predictor state and config mirror
    logic [63:0] prev_val     = '0;
    logic        delta_mirror = 1'b1;

    t_dir_row    dir_tab [DIR_ROWS];
    t_dir_row    row_q [$];
    t_beat       byte_q [$];
    logic [63:0] last_sent = '0;
    int          fail_count = 0;
    int          stall_cycles = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;

    delta_zigzag_varint_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_dir_row tab_row(input logic m, input logic [63:0] v, input logic r,
                                         input logic k, input logic [3:0] n,
                                         input logic [79:0] e);
        t_dir_row row;
        row = {m, v, r, k, n, e};
        return row;
    endfunction

    // varint bytes of one value; advances the previous-value state
    function automatic int varint_predict(input logic [63:0] v, input logic rs,
                                          output logic [79:0] enc);
        logic [63:0] d;
        logic [63:0] p;
        logic [7:0]  grp;
        int          n;
        if (rs) prev_val = '0;
        d = v - prev_val;
        p = delta_mirror ? ((d << 1) ^ {64{d[SIGN_BIT]}}) : v;
        prev_val = v;
        enc = '0;
        n = 0;
        do begin
            grp = p[7:0] & GROUP_MASK;
            p = p >> GROUP_BITS;
            enc[8*n +: 8] = (p != '0) ? (grp | MORE_FLAG) : grp;
            n++;
        end while (p != '0);
        return n;
    endfunction

    // random value: mostly small deltas off the base, some wide and corner values
    function automatic logic [63:0] pick_value(input logic [63:0] base);
        logic [63:0] r;
        logic [63:0] d;
        int          sel;
        int          w;
        r   = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (sel <= 4) w = $urandom_range(0, 13);
        else if (sel == 5) w = $urandom_range(14, 63);
        else w = $urandom_range(1, 63);
        d = r & ((64'd1 << w) - 64'd1);
        if (sel <= 5) begin
            return ($urandom_range(0, 1) != 0) ? base + d : base - d;
        end
        if (sel <= 7) return d;
        if (sel == 8) return r;
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return base;
            default: return ~base;
        endcase
    endfunction

    // sender: optional gap, then hold the beat until accepted
    task automatic send_value(input t_dir_row row);
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        row_q.insert(row_q.size(), row);
        last_sent = row.value;
        i_valid   <= 1'b1;
        i_value   <= row.value;
        i_restart <= row.restart;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (byte_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        delta_mirror = m;
    endtask

    // intake: build expected beats for each accepted item
    always @(posedge i_clk) begin : intake_mon
        t_dir_row    row;
        logic [79:0] enc;
        t_beat       bt;
        int          n;
        if (i_rst_n && i_valid && o_ready) begin
            row = row_q.pop_front();
            n = varint_predict(i_value, i_restart, enc);
            if (row.known) begin
                n   = int'(row.cnt);
                enc = row.enc;
            end
            for (int k = 0; k < n; k++) begin
                bt = {enc[8*k +: 8], (k == n - 1)};
                byte_q.insert(byte_q.size(), bt);
            end
        end
    end

    // output side: compare each accepted beat with the oldest expectation
    always @(posedge i_clk) begin : output_mon
        t_beat bt;
        if (i_rst_n && o_valid && i_ready) begin
            if (byte_q.size() == 0) begin
                $display("%0t: unexpected beat byte=%02h last=%0b",
                         $time, o_out_byte, o_last_byte);
                fail_count++;
            end else begin
                bt = byte_q.pop_front();
                if (o_out_byte !== bt.b) begin
                    $display("%0t: out_byte expected %02h actual %02h",
                             $time, bt.b, o_out_byte);
                    fail_count++;
                end
                if (o_last_byte !== bt.last) begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, bt.last, o_last_byte);
                    fail_count++;
                end
            end
        end
    end

    // receiver: ~10% stalls, calm stretches, one long hold-off on request
    initial begin : rx_side
        int k;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge i_clk);
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stim
        t_dir_row row;
        logic     rs;

        // delta mode from reset
        dir_tab[0]  = tab_row(1'b1, 64'd0, 1'b0, 1'b1, 4'd1, 80'h00);
        dir_tab[1]  = tab_row(1'b1, 64'd1, 1'b0, 1'b0, 4'd0, '0);
        dir_tab[2]  = tab_row(1'b1, 64'd0, 1'b0, 1'b0, 4'd0, '0);
        dir_tab[3]  = tab_row(1'b1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 4'd0, '0);
        dir_tab[4]  = tab_row(1'b1, '1, 1'b1, 1'b0, 4'd0, '0);
        dir_tab[5]  = tab_row(1'b1, 64'd0, 1'b0, 1'b0, 4'd0, '0);
        dir_tab[6]  = tab_row(1'b1, 64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0, 4'd0, '0);
        dir_tab[7]  = tab_row(1'b1, 64'd63, 1'b1, 1'b0, 4'd0, '0);
        dir_tab[8]  = tab_row(1'b1, 64'd64, 1'b1, 1'b0, 4'd0, '0);
        // same value again: zero delta
        dir_tab[9]  = tab_row(1'b1, 64'd64, 1'b0, 1'b1, 4'd1, 80'h00);
        // plain mode extremes
        dir_tab[10] = tab_row(1'b0, 64'd0, 1'b0, 1'b1, 4'd1, 80'h00);
        dir_tab[11] = tab_row(1'b0, 64'd127, 1'b0, 1'b1, 4'd1, 80'h7f);
        dir_tab[12] = tab_row(1'b0, 64'd128, 1'b0, 1'b1, 4'd2, 80'h0180);
        dir_tab[13] = tab_row(1'b0, '1, 1'b0, 1'b1, 4'd10, 80'h01ff_ffff_ffff_ffff_ffff);
        dir_tab[14] = tab_row(1'b0, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 4'd10,
                              80'h0180_8080_8080_8080_8080);
        dir_tab[15] = tab_row(1'b0, 64'h0123_4567_89ab_cdef, 1'b1, 1'b0, 4'd0, '0);
        // back to delta: continues from the last plain-mode value
        dir_tab[16] = tab_row(1'b1, 64'h0123_4567_89ab_cdf0, 1'b0, 1'b0, 4'd0, '0);
        dir_tab[17] = tab_row(1'b1, 64'd0, 1'b1, 1'b1, 4'd1, 80'h00);
        dir_tab[18] = tab_row(1'b1, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 4'd0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_mode(1'b1);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_tab[i].mode != delta_mirror) set_mode(dir_tab[i].mode);
            send_value(dir_tab[i]);
        end

        // random phases, alternating mode; long hold-off early, calm middle phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            set_mode(ph % 2 != 0);
            calm = (ph == 2);
            for (int j = 0; j < PHASE_ITEMS; j++) begin
                if (ph == 0 && j == 40) hold_req = 1'b1;
                rs  = ($urandom_range(0, 7) == 0);
                row = tab_row(delta_mirror, pick_value(rs ? 64'd0 : last_sent), rs,
                              1'b0, 4'd0, '0);
                send_value(row);
            end
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
